@@ sv/tlc_pkg.sv @@
// Shared types and constants for the three-level exclusive LFU cache.
`default_nettype none
package tlc_pkg;
    localparam int ADDR_W = 12;
    localparam int TAG_W  = 12;
    localparam int CNT_W  = 16;
    localparam int WORD_W = 32;
    localparam int WORDS  = 4;
    localparam int LINE_W = WORD_W * WORDS;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] HIT_L1  = 2'd0;
    localparam logic [1:0] HIT_L2  = 2'd1;
    localparam logic [1:0] HIT_L3  = 2'd2;
    localparam logic [1:0] HIT_RAM = 2'd3;

    typedef struct packed {
        logic                     action;
        logic [ADDR_W-1:0]        block_address;
        logic [1:0]               word_index;
        logic signed [WORD_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_data;
        logic [1:0]               hit_level;
    } t_rsp;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             dirty;
        logic [CNT_W-1:0] cnt;
    } t_meta;
endpackage
`default_nettype wire

@@ sv/three_level_exclusive_lfu_cache.sv @@
// Top level of the three-level exclusive LFU cache: sequencer, line moves and RAM.
// Sequence: reduce the block address, search L1, L2 and L3 in turn until a hit, load
// from RAM on a miss, move the line up one level at a time into L1, then finish and
// strobe the result.
// Throughput: one item at a time; busy is high from acceptance until the result strobe.
// Reset: sync, active low; empties all levels, then clears every RAM block with busy high.
`default_nettype none
module three_level_exclusive_lfu_cache #(
    parameter int L1_LINES   = 16,
    parameter int L2_LINES   = 16,
    parameter int L3_LINES   = 64,
    parameter int RAM_BLOCKS = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tlc_pkg::t_req i_req,
    output logic               o_done,
    output tlc_pkg::t_rsp      o_rsp
);
    localparam int IW1 = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
    localparam int IW2 = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;
    localparam int IW3 = (L3_LINES > 1) ? $clog2(L3_LINES) : 1;
    localparam int IWA = (IW1 > IW2) ? IW1 : IW2;
    localparam int IWM = (IWA > IW3) ? IWA : IW3;
    localparam int RA  = $clog2(RAM_BLOCKS);
    localparam int LW  = tlc_pkg::LINE_W;
    localparam int WW  = tlc_pkg::WORD_W;

    // Reciprocal of RAM_BLOCKS, exact for every 12-bit address up to 17-bit divisors.
    localparam int RSH = 29;
    localparam int DW  = 17;
    localparam int QW  = tlc_pkg::ADDR_W + RSH;
    localparam int PW  = tlc_pkg::ADDR_W + DW;
    localparam logic [RSH-1:0] RMUL =
        RSH'(((64'd1 << RSH) + 64'(RAM_BLOCKS) - 64'd1) / 64'(RAM_BLOCKS));
    localparam logic [DW-1:0]  RDEN = DW'(RAM_BLOCKS);

    localparam logic [IWM:0] LN1 = (IWM+1)'(L1_LINES);
    localparam logic [IWM:0] LN2 = (IWM+1)'(L2_LINES);
    localparam logic [IWM:0] LN3 = (IWM+1)'(L3_LINES);
    localparam logic [RA:0]   RLAST = (RA+1)'(RAM_BLOCKS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RED, S_SCAN, S_DEC,
        S_MV32_R, S_MV32_W, S_MV21_R, S_MV21_W, S_LD_R, S_LD_W, S_FIN_R, S_FIN_W
    } t_state;

    typedef enum logic [1:0] {LV1, LV2, LV3} t_lvl;

    t_state r_state;
    t_lvl   r_lv;

    // Request held for the whole access.
    logic                       r_act;
    logic [tlc_pkg::ADDR_W-1:0] r_addr;
    logic [1:0]                 r_word;
    logic [WW-1:0]              r_wd;
    logic [tlc_pkg::TAG_W-1:0]  r_tag;

    // Address reduction modulo RAM_BLOCKS: the quotient comes from a reciprocal
    // multiply at acceptance and the remainder is formed in the next cycle.
    logic [tlc_pkg::ADDR_W-1:0] r_q;
    logic [QW-1:0]              quo_prod;
    logic [PW-1:0]              den_prod;
    logic [tlc_pkg::ADDR_W-1:0] rem_nx;

    logic [RA:0] r_clr;

    // Search state: address issue, pending compare and running results.
    logic [IWM:0]   r_ai;
    logic           r_pv;
    logic [IWM-1:0] r_pi;
    logic           r_hf, r_ff;
    logic [IWM-1:0] r_hi, r_fi, r_mi;
    logic           r_hd, r_md;
    logic [tlc_pkg::CNT_W-1:0] r_hc, r_mc;
    logic [tlc_pkg::TAG_W-1:0] r_mt;

    // Per-level destination slot, fullness and victim identity.
    logic [IW1-1:0] r_d1;
    logic [IW2-1:0] r_d2;
    logic [IW3-1:0] r_d3;
    logic           r_f1, r_f2, r_f3;
    logic [tlc_pkg::TAG_W-1:0] r_vt1, r_vt2, r_vt3;
    logic           r_vd1, r_vd2, r_vd3;

    // The moving line: its source slot, dirty bit and final L1 use count.
    logic [IWM-1:0] r_s;
    logic           r_ld;
    logic [tlc_pkg::CNT_W-1:0] r_cnt;
    logic [1:0]     r_lvl;

    logic          r_done;
    tlc_pkg::t_rsp r_rsp;

    tlc_pkg::t_meta m1_r, m2_r, m3_r, m1_w, m2_w, m3_w, sm;
    logic           v1_r, v2_r, v3_r, sv;
    logic           m1_we, m2_we, m3_we, m1_wv, m2_wv, m3_wv;
    logic [IW1-1:0] m1_wa;
    logic [IW2-1:0] m2_wa;
    logic [IW3-1:0] m3_wa;
    logic [IWM:0]   lines;
    logic [tlc_pkg::CNT_W-1:0] cnt_inc;

    logic [LW-1:0]  l1_rd, l2_rd, l3_rd, ram_rd;
    logic [LW-1:0]  l1_wd, l2_wd, l3_wd, ram_wd, l1_mod;
    logic           l1_we, l2_we, l3_we, ram_we;
    logic [IW2-1:0] l2_ra, l2_wa;
    logic [IW3-1:0] l3_ra, l3_wa;
    logic [RA-1:0]  ram_wa;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign quo_prod = QW'(i_req.block_address) * QW'(RMUL);
    assign den_prod = PW'(r_q) * PW'(RDEN);
    assign rem_nx   = r_addr - den_prod[tlc_pkg::ADDR_W-1:0];
    assign cnt_inc  = (r_hc == tlc_pkg::COUNT_MAX) ? r_hc : (r_hc + 1'b1);

    always_comb begin
        case (r_lv)
            LV1:     begin sm = m1_r; sv = v1_r; lines = LN1; end
            LV2:     begin sm = m2_r; sv = v2_r; lines = LN2; end
            LV3:     begin sm = m3_r; sv = v3_r; lines = LN3; end
            default: begin sm = m1_r; sv = v1_r; lines = LN1; end
        endcase
    end

    // Metadata writes: entering lines get count zero; a swapped victim drops into the
    // source slot, and a line that moved into a free slot leaves its source empty.
    always_comb begin
        m1_we = (r_state == S_FIN_W);
        m1_wa = r_d1;
        m1_wv = 1'b1;
        m1_w  = '{tag: r_tag, dirty: r_ld | r_act, cnt: r_cnt};

        m2_we = (r_state == S_MV32_W) || (r_state == S_MV21_W);
        if (r_state == S_MV32_W) begin
            m2_wa = r_d2;
            m2_wv = 1'b1;
            m2_w  = '{tag: r_tag, dirty: r_ld, cnt: '0};
        end else begin
            m2_wa = r_s[IW2-1:0];
            m2_wv = r_f1;
            m2_w  = '{tag: r_vt1, dirty: r_vd1, cnt: '0};
        end

        m3_we = (r_state == S_LD_W) || (r_state == S_MV32_W);
        if (r_state == S_LD_W) begin
            m3_wa = r_d3;
            m3_wv = 1'b1;
            m3_w  = '{tag: r_tag, dirty: 1'b0, cnt: '0};
        end else begin
            m3_wa = r_s[IW3-1:0];
            m3_wv = r_f2;
            m3_w  = '{tag: r_vt2, dirty: r_vd2, cnt: '0};
        end
    end

    // Line data paths. Reads are issued in the _R states and the swap or fill is
    // written in the following _W state.
    always_comb begin
        l1_mod = l1_rd;
        l1_mod[r_word*WW +: WW] = r_wd;

        l1_we = (r_state == S_MV21_W) || ((r_state == S_FIN_W) && r_act);
        l1_wd = (r_state == S_MV21_W) ? l2_rd : l1_mod;

        l2_ra = (r_state == S_MV32_R) ? r_d2 : r_s[IW2-1:0];
        l2_we = (r_state == S_MV32_W) || ((r_state == S_MV21_W) && r_f1);
        l2_wa = (r_state == S_MV32_W) ? r_d2 : r_s[IW2-1:0];
        l2_wd = (r_state == S_MV32_W) ? l3_rd : l1_rd;

        l3_ra = (r_state == S_LD_R) ? r_d3 : r_s[IW3-1:0];
        l3_we = (r_state == S_LD_W) || ((r_state == S_MV32_W) && r_f2);
        l3_wa = (r_state == S_LD_W) ? r_d3 : r_s[IW3-1:0];
        l3_wd = (r_state == S_LD_W) ? ram_rd : l2_rd;

        // A dirty victim goes back to RAM while its slot is refilled.
        ram_we = (r_state == S_CLR) || ((r_state == S_LD_W) && r_f3 && r_vd3);
        ram_wa = (r_state == S_CLR) ? r_clr[RA-1:0] : RA'(r_vt3);
        ram_wd = (r_state == S_CLR) ? '0 : l3_rd;
    end

    tlc_meta #(.LINES(L1_LINES)) u_meta1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(r_ai[IW1-1:0]),
        .o_rmeta(m1_r), .o_rvalid(v1_r), .i_we(m1_we), .i_waddr(m1_wa),
        .i_wvalid(m1_wv), .i_wmeta(m1_w)
    );

    tlc_meta #(.LINES(L2_LINES)) u_meta2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(r_ai[IW2-1:0]),
        .o_rmeta(m2_r), .o_rvalid(v2_r), .i_we(m2_we), .i_waddr(m2_wa),
        .i_wvalid(m2_wv), .i_wmeta(m2_w)
    );

    tlc_meta #(.LINES(L3_LINES)) u_meta3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(r_ai[IW3-1:0]),
        .o_rmeta(m3_r), .o_rvalid(v3_r), .i_we(m3_we), .i_waddr(m3_wa),
        .i_wvalid(m3_wv), .i_wmeta(m3_w)
    );

    tlc_line_mem #(.DEPTH(L1_LINES)) u_l1 (
        .i_clk(i_clk), .i_we(l1_we), .i_waddr(r_d1), .i_wdata(l1_wd),
        .i_raddr(r_d1), .o_rdata(l1_rd)
    );

    tlc_line_mem #(.DEPTH(L2_LINES)) u_l2 (
        .i_clk(i_clk), .i_we(l2_we), .i_waddr(l2_wa), .i_wdata(l2_wd),
        .i_raddr(l2_ra), .o_rdata(l2_rd)
    );

    tlc_line_mem #(.DEPTH(L3_LINES)) u_l3 (
        .i_clk(i_clk), .i_we(l3_we), .i_waddr(l3_wa), .i_wdata(l3_wd),
        .i_raddr(l3_ra), .o_rdata(l3_rd)
    );

    tlc_line_mem #(.DEPTH(RAM_BLOCKS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(RA'(r_tag)), .o_rdata(ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_lv    <= LV1;
            r_pv    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == RLAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_act   <= i_req.action;
                        r_addr  <= i_req.block_address;
                        r_word  <= i_req.word_index;
                        r_wd    <= i_req.write_data;
                        r_q     <= quo_prod[QW-1:RSH];
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_tag   <= tlc_pkg::TAG_W'(rem_nx);
                    r_lv    <= LV1;
                    r_ai    <= '0;
                    r_pv    <= 1'b0;
                    r_hf    <= 1'b0;
                    r_ff    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // One entry is read per cycle and compared the cycle after.
                    if (r_ai < lines) begin
                        r_ai <= r_ai + 1'b1;
                        r_pi <= r_ai[IWM-1:0];
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_DEC;
                        end
                    end
                    if (r_pv) begin
                        if (!r_hf && sv && (sm.tag == r_tag)) begin
                            r_hf <= 1'b1;
                            r_hi <= r_pi;
                            r_hd <= sm.dirty;
                            r_hc <= sm.cnt;
                        end
                        if (!r_ff && !sv) begin
                            r_ff <= 1'b1;
                            r_fi <= r_pi;
                        end
                        // First minimum: only a strictly lower count displaces it.
                        if ((r_pi == '0) || (sm.cnt < r_mc)) begin
                            r_mc <= sm.cnt;
                            r_mi <= r_pi;
                            r_mt <= sm.tag;
                            r_md <= sm.dirty;
                        end
                    end
                end
                S_DEC: begin
                    r_ai <= '0;
                    r_hf <= 1'b0;
                    r_ff <= 1'b0;
                    case (r_lv)
                        LV1: begin
                            r_d1  <= r_hf ? IW1'(r_hi) : (r_ff ? IW1'(r_fi) : IW1'(r_mi));
                            r_f1  <= !r_ff;
                            r_vt1 <= r_mt;
                            r_vd1 <= r_md;
                            if (r_hf) begin
                                r_ld    <= r_hd;
                                r_cnt   <= cnt_inc;
                                r_lvl   <= tlc_pkg::HIT_L1;
                                r_state <= S_FIN_R;
                            end else begin
                                r_lv    <= LV2;
                                r_state <= S_SCAN;
                            end
                        end
                        LV2: begin
                            r_d2  <= r_ff ? IW2'(r_fi) : IW2'(r_mi);
                            r_f2  <= !r_ff;
                            r_vt2 <= r_mt;
                            r_vd2 <= r_md;
                            if (r_hf) begin
                                r_s     <= r_hi;
                                r_ld    <= r_hd;
                                r_lvl   <= tlc_pkg::HIT_L2;
                                r_state <= S_MV21_R;
                            end else begin
                                r_lv    <= LV3;
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            r_d3  <= r_ff ? IW3'(r_fi) : IW3'(r_mi);
                            r_f3  <= !r_ff;
                            r_vt3 <= r_mt;
                            r_vd3 <= r_md;
                            if (r_hf) begin
                                r_s     <= r_hi;
                                r_ld    <= r_hd;
                                r_lvl   <= tlc_pkg::HIT_L3;
                                r_state <= S_MV32_R;
                            end else begin
                                r_lvl   <= tlc_pkg::HIT_RAM;
                                r_state <= S_LD_R;
                            end
                        end
                    endcase
                end
                S_LD_R: begin
                    r_state <= S_LD_W;
                end
                S_LD_W: begin
                    r_s     <= IWM'(r_d3);
                    r_ld    <= 1'b0;
                    r_state <= S_MV32_R;
                end
                S_MV32_R: begin
                    r_state <= S_MV32_W;
                end
                S_MV32_W: begin
                    r_s     <= IWM'(r_d2);
                    r_state <= S_MV21_R;
                end
                S_MV21_R: begin
                    r_state <= S_MV21_W;
                end
                S_MV21_W: begin
                    r_cnt   <= '0;
                    r_state <= S_FIN_R;
                end
                S_FIN_R: begin
                    r_state <= S_FIN_W;
                end
                S_FIN_W: begin
                    r_done          <= 1'b1;
                    r_rsp.read_data <= r_act ? r_wd : l1_rd[r_word*WW +: WW];
                    r_rsp.hit_level <= r_lvl;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // A result is shown only once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    // An accepted beat always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat did not start work");

    // A move from L3 to L2 writes both levels' metadata in the same cycle.
    a_move_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MV32_W) |-> (m2_we && m3_we)) else $error("incomplete line move");
`endif
endmodule
`default_nettype wire

@@ sv/tlc_meta.sv @@
// Line metadata store of one cache level: valid flops plus a tag/dirty/count memory.
`default_nettype none
module tlc_meta #(
    parameter int LINES = 16,
    localparam int IW = (LINES > 1) ? $clog2(LINES) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [IW-1:0]  i_raddr,
    output tlc_pkg::t_meta      o_rmeta,
    output logic                o_rvalid,
    input  wire logic           i_we,
    input  wire logic [IW-1:0]  i_waddr,
    input  wire logic           i_wvalid,
    input  wire tlc_pkg::t_meta i_wmeta
);
    tlc_pkg::t_meta r_mem [LINES];
    logic [LINES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wmeta;
        end
        o_rmeta <= r_mem[i_raddr];
    end

    // Valid bits live in flops so that reset empties the level at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= i_wvalid;
            end
            o_rvalid <= r_valid[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/tlc_line_mem.sv @@
// Line-wide data memory with one write port and one registered read port.
`default_nettype none
module tlc_line_mem #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [tlc_pkg::LINE_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic [tlc_pkg::LINE_W-1:0]       o_rdata
);
    logic [tlc_pkg::LINE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
